### rtl/fsp_pkg.sv
// fsp_pkg: shared types and constants for the format string printer.
// Used by fsp_front, fsp_fifo, fsp_back and format_string_printer. No dependencies.

package fsp_pkg;

	localparam int CountBitsDefault = 16;
	localparam int FifoDepth        = 4;   // power of two
	localparam int CountOutBits     = 16;

	localparam logic [7:0] ChPercent = 8'h25;
	localparam logic [7:0] ChD       = 8'h64;
	localparam logic [7:0] ChX       = 8'h78;
	localparam logic [7:0] ChS       = 8'h73;
	localparam logic [7:0] ChMinus   = 8'h2d;
	localparam logic [7:0] ChZero    = 8'd48;
	localparam logic [7:0] ChAlphaOf = 8'd87;  // 'a' - 10

	// input item kinds
	typedef enum logic [2:0] {
		K_FMT  = 3'd0,
		K_END  = 3'd1,
		K_ARG  = 3'd2,
		K_SCHR = 3'd3,
		K_SEND = 3'd4
	} kind_t;

	// front-end parse mode
	typedef enum logic [2:0] {
		M_TEXT,
		M_PCT,
		M_DEC,
		M_HEX,
		M_STR
	} mode_t;

	// commands handed from front to back
	typedef enum logic [2:0] {
		OP_CHAR,   // printed and counted
		OP_RAW,    // printed, not counted
		OP_DONE,   // format end
		OP_DEC,    // signed decimal
		OP_HEX     // hex
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  chr;
		logic [31:0] arg;
	} cmd_t;

	// back-end sequencer
	typedef enum logic [2:0] {
		B_IDLE,
		B_CONV,
		B_LEAD,
		B_SIGN,
		B_DIGIT
	} bstate_t;

endpackage

### rtl/format_string_printer.sv
// format_string_printer: top level of a streaming printf-subset formatter.
// Instantiates fsp_front, fsp_fifo and fsp_back; depends on fsp_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, kind, byte_req, value) carries format
//   characters, format ends, numeric arguments and string-argument characters.
//   Output channel (out_valid/out_ready, ch, char_valid, last, done_res, count)
//   gives one transfer per printed character, or one done transfer answering a
//   format end with the saturated count. last marks the final result of an item.
//
//   The front tracks '%' conversions and pushes commands into a 4-entry queue;
//   it takes one input transfer per cycle while the queue has room, so ignored
//   items and mode changes wait on the output only through a full queue.
//   The back runs one command at a time into a single output register.
//   Each result passes through the queue and the result register; plain
//   characters sustain one per cycle while the receiver stays ready. A hex
//   argument emits its digits from the most significant nonzero one. A decimal
//   argument runs a 32-step binary-to-BCD loop, then emits sign and digits.
//
//   Reset clears the mode, the queue, the count and the output valid. When the
//   receiver stalls, the result register holds; the queue then fills and
//   in_ready drops once it is full.

module format_string_printer #(
	parameter int COUNT_BITS = fsp_pkg::CountBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [7:0]  byte_req,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  ch,
	output logic        char_valid,
	output logic        last,
	output logic        done_res,
	output logic [15:0] count
);
	import fsp_pkg::*;

	cmd_t push_cmd, head;
	logic push, full, pop, empty;

	fsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.byte_req (byte_req),
		.value    (value),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	// decouples parsing from the slow number conversion
	fsp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	fsp_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ch         (ch),
		.char_valid (char_valid),
		.last       (last),
		.done_res   (done_res),
		.count      (count)
	);

endmodule

### rtl/fsp_front.sv
// fsp_front: accepts input transfers, tracks the format mode, issues commands.
// Depends on fsp_pkg.

module fsp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    kind,
	input  logic [7:0]    byte_req,
	input  logic [31:0]   value,
	output logic          push,
	output fsp_pkg::cmd_t push_cmd,
	input  logic          full
);
	import fsp_pkg::*;

	mode_t mode_q, mode_next;
	logic  acc;

	assign in_ready = !full;
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_TEXT;
		end else begin
			mode_q <= mode_next;
		end
	end

	always_comb begin
		mode_next    = mode_q;
		push         = 1'b0;
		push_cmd.op  = OP_CHAR;
		push_cmd.chr = byte_req;
		push_cmd.arg = value;
		if (acc) begin
			unique case (mode_q)
				M_TEXT: begin
					if (kind == K_FMT) begin
						if (byte_req == ChPercent) begin
							mode_next = M_PCT;
						end else begin
							push = 1'b1;
						end
					end else if (kind == K_END) begin
						push        = 1'b1;
						push_cmd.op = OP_DONE;
					end
				end
				M_PCT: begin
					if (kind == K_FMT) begin
						priority if (byte_req == ChD) begin
							mode_next = M_DEC;
						end else if (byte_req == ChX) begin
							mode_next = M_HEX;
						end else if (byte_req == ChS) begin
							mode_next = M_STR;
						end else begin
							push        = 1'b1;
							push_cmd.op = OP_RAW;
							mode_next   = M_TEXT;
						end
					end else if (kind == K_END) begin
						push        = 1'b1;
						push_cmd.op = OP_DONE;
						mode_next   = M_TEXT;
					end
				end
				M_DEC: begin
					if (kind == K_ARG) begin
						push        = 1'b1;
						push_cmd.op = OP_DEC;
						mode_next   = M_TEXT;
					end
				end
				M_HEX: begin
					if (kind == K_ARG) begin
						push        = 1'b1;
						push_cmd.op = OP_HEX;
						mode_next   = M_TEXT;
					end
				end
				M_STR: begin
					if (kind == K_SCHR) begin
						push = 1'b1;
					end else if (kind == K_SEND) begin
						mode_next = M_TEXT;
					end
				end
				default: mode_next = M_TEXT;
			endcase
		end
	end

endmodule

### rtl/fsp_fifo.sv
// fsp_fifo: short command queue between front and back.
// Depends on fsp_pkg.

module fsp_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fsp_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output fsp_pkg::cmd_t head,
	output logic          empty
);
	import fsp_pkg::*;

	localparam int PtrW = $clog2(FifoDepth);

	cmd_t            mem_q [FifoDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0]   fill_q;

	assign full  = fill_q == (PtrW+1)'(FifoDepth);
	assign empty = fill_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

### rtl/fsp_back.sv
// fsp_back: executes commands, converts numbers, keeps the count, drives results.
// Depends on fsp_pkg.

module fsp_back #(
	parameter int COUNT_BITS = fsp_pkg::CountBitsDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  fsp_pkg::cmd_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    ch,
	output logic          char_valid,
	output logic          last,
	output logic          done_res,
	output logic [15:0]   count
);
	import fsp_pkg::*;

	localparam int ExtW = (COUNT_BITS > CountOutBits) ? COUNT_BITS : CountOutBits;
	localparam logic [COUNT_BITS-1:0] CntMax = '1;

	bstate_t st_q, st_next;
	logic [COUNT_BITS-1:0] cnt_q, cnt_inc;
	logic [ExtW-1:0]       cnt_ext;
	logic [39:0]           dig_q;      // BCD or hex nibbles
	logic [31:0]           sh_q;
	logic [4:0]            iter_q;
	logic [3:0]            idx_q, lead;
	logic                  neg_q;
	logic [3:0]            cur_dig;

	// result register
	logic        ov_q, cv_q, last_q, done_q;
	logic [7:0]  ch_q;
	logic [15:0] count_q;

	// emit request from the sequencer
	logic       can_emit, emit, e_cv, e_last, e_done, e_bump;
	logic [7:0] e_ch;

	// one double-dabble step: adjust every BCD digit, then shift in a bit
	function automatic logic [39:0] dabble(input logic [39:0] b, input logic bin);
		logic [39:0] a;
		a = b;
		for (int i = 0; i < 10; i++) begin
			if (a[4*i +: 4] >= 4'd5) a[4*i +: 4] = a[4*i +: 4] + 4'd3;
		end
		return {a[38:0], bin};
	endfunction

	assign cnt_inc  = (cnt_q == CntMax) ? cnt_q : cnt_q + 1'b1;
	assign can_emit = !ov_q || out_ready;
	assign cur_dig  = dig_q[idx_q*4 +: 4];

	// most significant nonzero digit, zero prints as one digit
	always_comb begin
		lead = '0;
		for (int i = 0; i < 10; i++) begin
			if (dig_q[4*i +: 4] != 4'd0) lead = 4'(i);
		end
	end

	always_comb begin
		st_next = st_q;
		pop     = 1'b0;
		emit    = 1'b0;
		e_ch    = 8'd0;
		e_cv    = 1'b1;
		e_last  = 1'b1;
		e_done  = 1'b0;
		e_bump  = 1'b0;
		unique case (st_q)
			B_IDLE: begin
				if (!empty && can_emit) begin
					pop = 1'b1;
					unique case (head.op)
						OP_CHAR: begin
							emit   = 1'b1;
							e_ch   = head.chr;
							e_bump = 1'b1;
						end
						OP_RAW: begin
							emit = 1'b1;
							e_ch = head.chr;
						end
						OP_DONE: begin
							emit   = 1'b1;
							e_cv   = 1'b0;
							e_done = 1'b1;
						end
						OP_DEC:  st_next = B_CONV;
						OP_HEX:  st_next = B_LEAD;
						default: st_next = B_IDLE;
					endcase
				end
			end
			B_CONV: begin
				if (iter_q == 5'd31) st_next = B_LEAD;
			end
			B_LEAD: st_next = neg_q ? B_SIGN : B_DIGIT;
			B_SIGN: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_ch    = ChMinus;
					e_last  = 1'b0;
					e_bump  = 1'b1;
					st_next = B_DIGIT;
				end
			end
			B_DIGIT: begin
				if (can_emit) begin
					emit   = 1'b1;
					e_ch   = (cur_dig < 4'd10) ? ChZero + 8'(cur_dig)
					                           : ChAlphaOf + 8'(cur_dig);
					e_last = idx_q == 4'd0;
					e_bump = 1'b1;
					if (idx_q == 4'd0) st_next = B_IDLE;
				end
			end
			default: st_next = B_IDLE;
		endcase
	end

	assign cnt_ext = ExtW'(e_bump ? cnt_inc : cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= B_IDLE;
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			st_q <= st_next;
			if (emit) begin
				ov_q  <= 1'b1;
				cnt_q <= e_done ? '0 : (e_bump ? cnt_inc : cnt_q);
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ch_q    <= e_ch;
			cv_q    <= e_cv;
			last_q  <= e_last;
			done_q  <= e_done;
			count_q <= cnt_ext[15:0];
		end
		unique case (st_q)
			B_IDLE: begin
				iter_q <= '0;
				if (pop && head.op == OP_DEC) begin
					neg_q <= head.arg[31];
					sh_q  <= head.arg[31] ? 32'd0 - head.arg : head.arg;
					dig_q <= '0;
				end else if (pop && head.op == OP_HEX) begin
					neg_q <= 1'b0;
					dig_q <= {8'd0, head.arg};
				end
			end
			B_CONV: begin
				dig_q  <= dabble(dig_q, sh_q[31]);
				sh_q   <= {sh_q[30:0], 1'b0};
				iter_q <= iter_q + 1'b1;
			end
			B_LEAD:  idx_q <= lead;
			B_DIGIT: if (emit) idx_q <= idx_q - 1'b1;
			default: ;
		endcase
	end

	assign out_valid  = ov_q;
	assign ch         = ch_q;
	assign char_valid = cv_q;
	assign last       = last_q;
	assign done_res   = done_q;
	assign count      = count_q;

endmodule

### rtl/fsp_checker.sv
// fsp_checker: port-level assertions for format_string_printer, with its bind.
// Depends on fsp_pkg for character constants.

module fsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] ch,
	input logic       char_valid,
	input logic       last,
	input logic       done_res
);
	import fsp_pkg::*;

	// a stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// every result is either a character or a done, never both
	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_valid != done_res))
		else $error("result is both or neither character and done");

	// done result is a single, empty result
	a_done_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> last && ch == 8'd0)
		else $error("malformed done result");

	// only number conversions give more than one result per item
	a_multi_num: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> ch == ChMinus
			|| (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h66))
		else $error("non-final result is not a number character");

endmodule

bind format_string_printer fsp_checker u_fsp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.ch         (ch),
	.char_valid (char_valid),
	.last       (last),
	.done_res   (done_res)
);

### tb/tb_format_string_printer.sv
// tb_format_string_printer: self-checking testbench for the printf-subset formatter.
// Depends on fsp_pkg and format_string_printer; a clocked driver and monitor
// run against an in-bench predictor of the format parser and counter.
`timescale 1ns / 100ps

module tb_format_string_printer;
	import fsp_pkg::*;

	// counter width matches the block's default parameter
	localparam int CountBits = CountBitsDefault;
	localparam logic [CountBits-1:0] CountMax = '1;
	localparam int CycleLimit = 3_000_000;
	localparam int RandPerPhase = 80;   // counted format items per idling phase
	localparam int TailCycles = 60;     // wait after the last phase, above the worst decimal conversion

	// one input transfer
	typedef struct {
		logic [2:0]  kind;
		logic [7:0]  chr;
		logic [31:0] val;
	} fmt_item_t;

	// one output transfer
	typedef struct {
		logic [7:0]  ch;
		logic        char_valid;
		logic        last;
		logic        done_res;
		logic [15:0] count;
	} print_res_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  kind = '0;
	logic [7:0]  byte_req = '0;
	logic [31:0] value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  ch;
	logic        char_valid;
	logic        last;
	logic        done_res;
	logic [15:0] count;

	format_string_printer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.byte_req  (byte_req),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ch        (ch),
		.char_valid(char_valid),
		.last      (last),
		.done_res  (done_res),
		.count     (count)
	);

	// pending input transfers and the printed characters they should cause
	fmt_item_t  fmt_items[$];
	print_res_t printed_exp[$];
	print_res_t step_burst[$];
	fmt_item_t  next_item;

	// idling odds in percent, changed only between phases
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int dones_seen = 0;
	int peak_count = 0;
	int cycles = 0;

	// predictor state: parse mode and saturating printed-character counter
	mode_t                pred_mode = M_TEXT;
	logic [CountBits-1:0] pred_count = '0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// append one result; counted chars bump the counter first so the
	// result shows its own character in the count
	task automatic emit(input logic [7:0] c, input logic is_char, input logic counted);
		print_res_t r;
		if (counted && pred_count != CountMax)
			pred_count = pred_count + 1'b1;
		r.ch = is_char ? c : 8'h00;
		r.char_valid = is_char;
		r.last = 1'b0;
		r.done_res = !is_char;
		r.count = pred_count[15:0];
		step_burst.push_back(r);
	endtask

	// digits most significant first, optional minus ahead of them;
	// zero still gives one digit
	task automatic emit_number(input logic [31:0] mag, input logic [31:0] base,
			input logic neg);
		logic [7:0]  digs[12];
		logic [31:0] d;
		int          nd;
		nd = 0;
		do begin
			d = mag % base;
			digs[nd] = (d < 10) ? ChZero + d[7:0] : ChAlphaOf + d[7:0];
			nd++;
			mag = mag / base;
		end while (mag != 0 && nd < 11);
		if (neg)
			emit(ChMinus, 1'b1, 1'b1);
		for (int i = nd - 1; i >= 0; i--)
			emit(digs[i], 1'b1, 1'b1);
	endtask

	// advance the parser by one accepted transfer and queue its results
	task automatic format_step(input logic [2:0] k, input logic [7:0] c,
			input logic [31:0] v);
		step_burst.delete();
		case (pred_mode)
			M_TEXT: begin
				if (k == K_FMT) begin
					if (c == ChPercent)
						pred_mode = M_PCT;
					else
						emit(c, 1'b1, 1'b1);
				end else if (k == K_END) begin
					emit(8'h00, 1'b0, 1'b0);
					pred_count = '0;
				end
			end
			M_PCT: begin
				if (k == K_FMT) begin
					if (c == ChD)
						pred_mode = M_DEC;
					else if (c == ChX)
						pred_mode = M_HEX;
					else if (c == ChS)
						pred_mode = M_STR;
					else begin
						// unknown conversion: echoed but left out of the count
						emit(c, 1'b1, 1'b0);
						pred_mode = M_TEXT;
					end
				end else if (k == K_END) begin
					// trailing percent prints nothing
					emit(8'h00, 1'b0, 1'b0);
					pred_count = '0;
					pred_mode = M_TEXT;
				end
			end
			M_DEC: begin
				if (k == K_ARG) begin
					emit_number(v[31] ? (32'd0 - v) : v, 32'd10, v[31]);
					pred_mode = M_TEXT;
				end
			end
			M_HEX: begin
				if (k == K_ARG) begin
					emit_number(v, 32'd16, 1'b0);
					pred_mode = M_TEXT;
				end
			end
			M_STR: begin
				if (k == K_SCHR)
					emit(c, 1'b1, 1'b1);
				else if (k == K_SEND)
					pred_mode = M_TEXT;
			end
			default: pred_mode = M_TEXT;
		endcase
		if (step_burst.size() != 0)
			step_burst[step_burst.size() - 1].last = 1'b1;
		foreach (step_burst[i])
			printed_exp.push_back(step_burst[i]);
	endtask

	// ------------------------------------------------------------------
	// driver: presents queued items, predicts on each accepted transfer
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= '0;
			byte_req <= '0;
			value <= '0;
		end else begin
			if (in_valid && in_ready) begin
				format_step(kind, byte_req, value);
				items_sent++;
			end
			// payload may only change once the current item is gone
			if (!in_valid || in_ready) begin
				if (fmt_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_item = fmt_items.pop_front();
					in_valid <= 1'b1;
					kind <= next_item.kind;
					byte_req <= next_item.chr;
					value <= next_item.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: random back-pressure, checks each output transfer
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (done_res)
					dones_seen++;
				if (count > peak_count)
					peak_count = count;
				if (printed_exp.size() == 0) begin
					$error("unexpected output transfer: ch=%h done_res=%b", ch, done_res);
					mismatches++;
				end else begin
					if (ch !== printed_exp[0].ch) begin
						$error("ch: expected %h, got %h", printed_exp[0].ch, ch);
						mismatches++;
					end
					if (char_valid !== printed_exp[0].char_valid) begin
						$error("char_valid: expected %b, got %b",
							printed_exp[0].char_valid, char_valid);
						mismatches++;
					end
					if (last !== printed_exp[0].last) begin
						$error("last: expected %b, got %b", printed_exp[0].last, last);
						mismatches++;
					end
					if (done_res !== printed_exp[0].done_res) begin
						$error("done_res: expected %b, got %b",
							printed_exp[0].done_res, done_res);
						mismatches++;
					end
					if (count !== printed_exp[0].count) begin
						$error("count: expected %0d, got %0d", printed_exp[0].count, count);
						mismatches++;
					end
					void'(printed_exp.pop_front());
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic add_item(input logic [2:0] k, input logic [7:0] c, input logic [31:0] v);
		fmt_item_t it;
		it.kind = k;
		it.chr = c;
		it.val = v;
		fmt_items.push_back(it);
	endtask

	// argument bits biased toward zero, the extremes and short numbers
	function automatic logic [31:0] pick_arg();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	// one well-formed format with random content, mostly closed by a format end
	task automatic gen_format();
		int          nseg;
		int          slen;
		logic [7:0]  c;
		nseg = $urandom_range(1, 6);
		for (int s = 0; s < nseg; s++) begin
			case ($urandom_range(0, 9))
				4: begin
					add_item(K_FMT, ChPercent, $urandom);
					add_item(K_FMT, ChD, $urandom);
					add_item(K_ARG, 8'($urandom), pick_arg());
				end
				5: begin
					add_item(K_FMT, ChPercent, $urandom);
					add_item(K_FMT, ChX, $urandom);
					add_item(K_ARG, 8'($urandom), pick_arg());
				end
				6: begin
					add_item(K_FMT, ChPercent, $urandom);
					add_item(K_FMT, ChS, $urandom);
					slen = $urandom_range(0, 6);
					for (int j = 0; j < slen; j++)
						add_item(K_SCHR, 8'($urandom_range(0, 255)), $urandom);
					add_item(K_SEND, 8'($urandom), $urandom);
				end
				7: begin
					// unknown conversion, a second percent standing in for d/x/s
					c = 8'($urandom_range(0, 255));
					if (c == ChD || c == ChX || c == ChS)
						c = ChPercent;
					add_item(K_FMT, ChPercent, $urandom);
					add_item(K_FMT, c, $urandom);
				end
				8: begin
					// a stray transfer of the wrong kind while an argument is awaited
					add_item(K_FMT, ChPercent, $urandom);
					add_item(K_FMT, $urandom_range(0, 1) ? ChD : ChX, $urandom);
					add_item($urandom_range(0, 1) ? K_FMT : K_SCHR, 8'($urandom), $urandom);
					add_item(K_ARG, 8'($urandom), pick_arg());
				end
				default: add_item(K_FMT, 8'($urandom_range(0, 255)), $urandom);
			endcase
		end
		if ($urandom_range(0, 9) == 0)
			add_item(K_FMT, ChPercent, $urandom);
		if ($urandom_range(0, 19) != 0)
			add_item(K_END, 8'($urandom), $urandom);
	endtask

	// noise: any kind, including the unused codes, with random payload
	task automatic gen_noise();
		int n;
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++)
			add_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), $urandom);
	endtask

	// hold the sender until the queue is empty and every result has arrived
	task automatic drain_all();
		while (fmt_items.size() != 0 || in_valid || printed_exp.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		int before_cnt;
		int noise_start;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: byte extremes, every conversion, zero and extreme arguments,
		// strings with a zero byte, unknown and trailing percent, ignored kinds
		add_item(K_FMT, 8'h41, 32'h0);
		add_item(K_FMT, 8'h00, 32'h0);
		add_item(K_FMT, 8'hFF, 32'hFFFF_FFFF);
		add_item(K_ARG, 8'h00, 32'h1234_5678);
		add_item(K_FMT, ChPercent, 32'h0);
		add_item(K_FMT, ChD, 32'h0);
		add_item(K_ARG, 8'h00, 32'h0000_0000);
		add_item(K_FMT, ChPercent, 32'h0);
		add_item(K_FMT, ChD, 32'h0);
		add_item(K_FMT, 8'h7A, 32'h0);
		add_item(K_ARG, 8'hFF, 32'h8000_0000);
		add_item(K_FMT, ChPercent, 32'h0);
		add_item(K_FMT, ChD, 32'h0);
		add_item(K_ARG, 8'h00, 32'h7FFF_FFFF);
		add_item(K_FMT, ChPercent, 32'h0);
		add_item(K_FMT, ChX, 32'h0);
		add_item(K_ARG, 8'h00, 32'h0000_0000);
		add_item(K_FMT, ChPercent, 32'h0);
		add_item(K_FMT, ChX, 32'h0);
		add_item(K_ARG, 8'h00, 32'hFFFF_FFFF);
		add_item(K_FMT, ChPercent, 32'h0);
		add_item(K_FMT, ChS, 32'h0);
		add_item(K_SCHR, 8'h00, 32'h0);
		add_item(K_END, 8'h00, 32'h0);
		add_item(K_SCHR, 8'hFF, 32'h0);
		add_item(K_SEND, 8'h00, 32'h0);
		add_item(K_FMT, ChPercent, 32'h0);
		add_item(K_FMT, ChPercent, 32'h0);
		add_item(K_FMT, ChPercent, 32'h0);
		add_item(K_FMT, 8'h71, 32'h0);
		add_item(3'd5, 8'h41, 32'h0);
		add_item(3'd6, 8'h41, 32'h0);
		add_item(3'd7, 8'h41, 32'h0);
		add_item(K_END, 8'h00, 32'h0);
		add_item(K_FMT, ChPercent, 32'h0);
		add_item(K_END, 8'h00, 32'h0);
		drain_all();

		// random phases: none, sender idle, receiver stall, both
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			before_cnt = fmt_items.size();
			while (fmt_items.size() - before_cnt < RandPerPhase) begin
				if ($urandom_range(0, 9) < 8)
					gen_format();
				else begin
					// noise does not count toward the phase total
					noise_start = fmt_items.size();
					gen_noise();
					before_cnt = before_cnt + (fmt_items.size() - noise_start);
				end
			end
			drain_all();
		end

		repeat (TailCycles) @(negedge clk);
		if (printed_exp.size() != 0) begin
			$error("%0d expected results never arrived", printed_exp.size());
			mismatches++;
		end

		$display("Run covered %0d input transfers, %0d output transfers, %0d format ends.",
			items_sent, results_seen, dones_seen);
		$display("Peak count %0d; idling phases none, sender, receiver and both.",
			peak_count);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
rtl/fsp_pkg.sv
rtl/fsp_front.sv
rtl/fsp_fifo.sv
rtl/fsp_back.sv
rtl/format_string_printer.sv
rtl/fsp_checker.sv
tb/tb_format_string_printer.sv
